/* rtl/core/keypad_set_countdown_timer_assert.svh */
// Assertion macros used by the timer top module.
`ifndef KEYPAD_SET_COUNTDOWN_TIMER_ASSERT_SVH
`define KEYPAD_SET_COUNTDOWN_TIMER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KCT_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kct: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KCT_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kct: next-cycle check failed");

`endif

/* rtl/core/kct_pkg.sv */
package kct_pkg;

  localparam int COUNT_W    = 20;
  localparam int VALUE_W    = 14;
  localparam int KEY_W      = 4;
  localparam int PROD_W     = 17;

  localparam int MAX_DIGITS = 4;

  localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
  localparam logic [KEY_W-1:0] KEY_C         = 4'd12;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd14;
  localparam logic [KEY_W-1:0] KEY_HASH      = 4'd15;

  localparam int VALUE_LIMIT = 9999;
  localparam int DIGIT_BASE  = 10;
  localparam int SEC_PER_MIN = 60;

  typedef enum logic [1:0] {
    PH_RUN = 2'd0,
    PH_MIN = 2'd1,
    PH_SEC = 2'd2
  } phase_t;

  typedef struct packed {
    logic [COUNT_W-1:0] remaining_seconds;
    logic               led_on;
    phase_t             phase;
    logic [VALUE_W-1:0] entry_value;
  } result_t;

endpackage

/* rtl/core/kct_core.sv */
module kct_core #(
  parameter int MAX_DIGITS = kct_pkg::MAX_DIGITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic                        mode,
  input  logic [kct_pkg::KEY_W-1:0]   key_code,
  output kct_pkg::result_t            res_next
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int CW    = kct_pkg::COUNT_W;
  localparam int VW    = kct_pkg::VALUE_W;
  localparam int PW    = kct_pkg::PROD_W;

  logic [CW-1:0]    countdown, countdown_next;
  logic [VW-1:0]    minutes_held, minutes_held_next;
  logic [VW-1:0]    digit_value, digit_value_next;
  logic [CNT_W-1:0] digit_count, digit_count_next;
  kct_pkg::phase_t  entry_phase, entry_phase_next;

  logic [PW-1:0]    digit_cand;
  logic             digit_ok;
  logic [CW-1:0]    load_value;

  assign digit_cand = {{(PW-VW){1'b0}}, digit_value} * PW'(kct_pkg::DIGIT_BASE)
                    + {{(PW-kct_pkg::KEY_W){1'b0}}, key_code};
  assign digit_ok   = (digit_count < CNT_W'(MAX_DIGITS))
                    && (digit_cand <= PW'(kct_pkg::VALUE_LIMIT));
  assign load_value = {{(CW-VW){1'b0}}, minutes_held} * CW'(kct_pkg::SEC_PER_MIN)
                    + {{(CW-VW){1'b0}}, digit_value};

  always_ff @(posedge clk) begin
    if (rst) begin
      countdown    <= '0;
      minutes_held <= '0;
      digit_value  <= '0;
      digit_count  <= '0;
      entry_phase  <= kct_pkg::PH_RUN;
    end else if (step) begin
      countdown    <= countdown_next;
      minutes_held <= minutes_held_next;
      digit_value  <= digit_value_next;
      digit_count  <= digit_count_next;
      entry_phase  <= entry_phase_next;
    end
  end

  // next state
  always_comb begin
    countdown_next    = countdown;
    minutes_held_next = minutes_held;
    digit_value_next  = digit_value;
    digit_count_next  = digit_count;
    entry_phase_next  = entry_phase;
    if (mode) begin
      if (countdown != '0) countdown_next = countdown - CW'(1);
    end else begin
      unique case (entry_phase)
        kct_pkg::PH_MIN: begin
          if (key_code <= kct_pkg::KEY_DIGIT_MAX) begin
            if (digit_ok) begin
              digit_value_next = digit_cand[VW-1:0];
              digit_count_next = digit_count + CNT_W'(1);
            end
          end else if (key_code == kct_pkg::KEY_STAR) begin
            minutes_held_next = digit_value;
            digit_value_next  = '0;
            digit_count_next  = '0;
            entry_phase_next  = kct_pkg::PH_SEC;
          end else if (key_code == kct_pkg::KEY_HASH) begin
            digit_value_next  = '0;
            digit_count_next  = '0;
            entry_phase_next  = kct_pkg::PH_RUN;
          end
        end
        kct_pkg::PH_SEC: begin
          if (key_code <= kct_pkg::KEY_DIGIT_MAX) begin
            if (digit_ok) begin
              digit_value_next = digit_cand[VW-1:0];
              digit_count_next = digit_count + CNT_W'(1);
            end
          end else if (key_code == kct_pkg::KEY_STAR || key_code == kct_pkg::KEY_HASH) begin
            countdown_next   = load_value;
            digit_value_next = '0;
            digit_count_next = '0;
            entry_phase_next = kct_pkg::PH_RUN;
          end else if (key_code == kct_pkg::KEY_C) begin
            countdown_next   = '0;
            digit_value_next = '0;
            digit_count_next = '0;
            entry_phase_next = kct_pkg::PH_RUN;
          end
        end
        default: begin
          // run phase; an unused code behaves the same
          if (key_code == kct_pkg::KEY_HASH) begin
            countdown_next    = '0;
            minutes_held_next = '0;
            digit_value_next  = '0;
            digit_count_next  = '0;
            entry_phase_next  = kct_pkg::PH_MIN;
          end
        end
      endcase
    end
  end

  // outputs, taken after the update
  always_comb begin
    res_next.remaining_seconds = countdown_next;
    res_next.phase             = entry_phase_next;
    res_next.entry_value       = digit_value_next;
    res_next.led_on            = (entry_phase_next != kct_pkg::PH_MIN)
                              && (entry_phase_next != kct_pkg::PH_SEC)
                              && (countdown_next != '0);
  end

endmodule

/* rtl/core/keypad_set_countdown_timer.sv */
// Channel | Handshake             | Beat
// --------+-----------------------+-------------------------------------------------
// input   | in_valid / in_stall   | mode, key_code
// output  | out_valid / out_stall | remaining_seconds, led_on, phase, entry_value
//
// One result per input beat, passing through the input register and then the result register.
// Sustains one beat per cycle while out_stall is low: the state update is a
// single pass of logic whose longest path is the minutes*60+seconds load.
// Reset (rst, synchronous) clears both stage valids and the timer state.
// A stalled result holds in the output register; in_stall rises only while the
// input register is full and the result cannot move.
module keypad_set_countdown_timer #(
  parameter int MAX_DIGITS = kct_pkg::MAX_DIGITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [kct_pkg::KEY_W-1:0]     key_code,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [kct_pkg::COUNT_W-1:0]   remaining_seconds,
  output logic                          led_on,
  output logic [1:0]                    phase,
  output logic [kct_pkg::VALUE_W-1:0]   entry_value
);

`include "keypad_set_countdown_timer_assert.svh"

  logic                        s1_valid;
  logic                        s1_mode;
  logic [kct_pkg::KEY_W-1:0]   s1_key;
  logic                        in_accept;
  logic                        advance;
  kct_pkg::result_t            res_next;
  kct_pkg::result_t            res;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_mode <= mode;
      s1_key  <= key_code;
    end
    if (advance) res <= res_next;
  end

  kct_core #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .mode     (s1_mode),
    .key_code (s1_key),
    .res_next (res_next)
  );

  assign remaining_seconds = res.remaining_seconds;
  assign led_on            = res.led_on;
  assign phase             = res.phase;
  assign entry_value       = res.entry_value;

  `KCT_ASSERT_IMP(a_led_run_nonzero, clk, rst, out_valid && led_on,
    remaining_seconds != '0 && phase == kct_pkg::PH_RUN)
  `KCT_ASSERT_IMP(a_min_entry_zero, clk, rst, out_valid && phase == kct_pkg::PH_MIN,
    remaining_seconds == '0 && !led_on)
  `KCT_ASSERT_IMP(a_entry_limit, clk, rst, out_valid,
    entry_value <= kct_pkg::VALUE_W'(kct_pkg::VALUE_LIMIT))
  `KCT_ASSERT_NXT(a_advance_fills_out, clk, rst, advance, out_valid)

endmodule

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // letter keys that have no name in the package
  localparam logic [kct_pkg::KEY_W-1:0] KEY_A = 4'd10;
  localparam logic [kct_pkg::KEY_W-1:0] KEY_B = 4'd11;
  localparam logic [kct_pkg::KEY_W-1:0] KEY_D = 4'd13;

  localparam int BEAT_TARGET = 1800;

  class timer_mirror;
    logic [kct_pkg::COUNT_W-1:0] countdown;
    logic [kct_pkg::VALUE_W-1:0] minutes_held;
    logic [kct_pkg::VALUE_W-1:0] digit_value;
    logic [2:0]                  digit_count;
    kct_pkg::phase_t             entry_phase;
    kct_pkg::result_t            pending_readouts[$];
    int                          mismatch_count;
    int                          checked_count;
    int                          load_count;
    int                          cancel_count;
    int                          expiry_count;

    function new();
      countdown      = '0;
      minutes_held   = '0;
      digit_value    = '0;
      digit_count    = '0;
      entry_phase    = kct_pkg::PH_RUN;
      mismatch_count = 0;
      checked_count  = 0;
      load_count     = 0;
      cancel_count   = 0;
      expiry_count   = 0;
    endfunction

    function void clear_digits();
      digit_value = '0;
      digit_count = '0;
    endfunction

    function void append_digit(logic [kct_pkg::KEY_W-1:0] d);
      int nxt;
      if (int'(digit_count) >= kct_pkg::MAX_DIGITS) return;
      nxt = int'(digit_value) * kct_pkg::DIGIT_BASE + int'(d);
      if (nxt > kct_pkg::VALUE_LIMIT) return;
      digit_value = kct_pkg::VALUE_W'(nxt);
      digit_count = digit_count + 3'd1;
    endfunction

    function kct_pkg::result_t advance_timer(logic m, logic [kct_pkg::KEY_W-1:0] k);
      kct_pkg::result_t r;
      int               total;
      if (m == MODE_TICK) begin
        if (countdown != '0) begin
          countdown = countdown - kct_pkg::COUNT_W'(1);
          if (countdown == '0) expiry_count++;
        end
      end else begin
        case (entry_phase)
          kct_pkg::PH_MIN: begin
            if (k <= kct_pkg::KEY_DIGIT_MAX) begin
              append_digit(k);
            end else if (k == kct_pkg::KEY_STAR) begin
              minutes_held = digit_value;
              clear_digits();
              entry_phase = kct_pkg::PH_SEC;
            end else if (k == kct_pkg::KEY_HASH) begin
              clear_digits();
              entry_phase = kct_pkg::PH_RUN;
              cancel_count++;
            end
          end
          kct_pkg::PH_SEC: begin
            if (k <= kct_pkg::KEY_DIGIT_MAX) begin
              append_digit(k);
            end else if (k == kct_pkg::KEY_STAR || k == kct_pkg::KEY_HASH) begin
              total = int'(minutes_held) * kct_pkg::SEC_PER_MIN + int'(digit_value);
              countdown = kct_pkg::COUNT_W'(total);
              clear_digits();
              entry_phase = kct_pkg::PH_RUN;
              load_count++;
            end else if (k == kct_pkg::KEY_C) begin
              countdown = '0;
              clear_digits();
              entry_phase = kct_pkg::PH_RUN;
              cancel_count++;
            end
          end
          default: begin
            if (k == kct_pkg::KEY_HASH) begin
              countdown = '0;
              minutes_held = '0;
              clear_digits();
              entry_phase = kct_pkg::PH_MIN;
            end
          end
        endcase
      end
      r.remaining_seconds = countdown;
      r.led_on            = (entry_phase != kct_pkg::PH_MIN
                             && entry_phase != kct_pkg::PH_SEC && countdown != '0);
      r.phase             = entry_phase;
      r.entry_value       = digit_value;
      return r;
    endfunction

    function void note_beat(logic m, logic [kct_pkg::KEY_W-1:0] k);
      pending_readouts.push_back(advance_timer(m, k));
    endfunction

    function void check_result(logic [kct_pkg::COUNT_W-1:0] rs, logic led, logic [1:0] ph,
                               logic [kct_pkg::VALUE_W-1:0] ev);
      kct_pkg::result_t want;
      bit               bad;
      checked_count++;
      if (pending_readouts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] unexpected result: rem=%0d led=%0d phase=%0d entry=%0d",
                   $realtime, rs, led, ph, ev);
        return;
      end
      want = pending_readouts.pop_front();
      bad = 1'b0;
      if (rs !== want.remaining_seconds) bad = 1'b1;
      if (led !== want.led_on) bad = 1'b1;
      if (ph !== 2'(want.phase)) bad = 1'b1;
      if (ev !== want.entry_value) bad = 1'b1;
      if (bad) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $write("[%0t] mismatch: expected rem=%0d led=%0d phase=%0d entry=%0d,",
                 $realtime, want.remaining_seconds, want.led_on, 2'(want.phase),
                 want.entry_value);
          $display(" got rem=%0d led=%0d phase=%0d entry=%0d", rs, led, ph, ev);
        end
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        mode = 1'b0;
  logic [kct_pkg::KEY_W-1:0]   key_code = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [kct_pkg::COUNT_W-1:0] remaining_seconds;
  logic                        led_on;
  logic [1:0]                  phase;
  logic [kct_pkg::VALUE_W-1:0] entry_value;

  timer_mirror board = new();
  int          sent_count = 0;
  int          burst_left = 0;

  always #2 clk = ~clk;

  keypad_set_countdown_timer u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .key_code          (key_code),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .remaining_seconds (remaining_seconds),
    .led_on            (led_on),
    .phase             (phase),
    .entry_value       (entry_value)
  );

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(remaining_seconds, led_on, phase, entry_value);
  end

  // Hold the beat until the edge that takes it.
  task automatic send_beat(input logic m, input logic [kct_pkg::KEY_W-1:0] k);
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= m;
    key_code <= k;
    do @(posedge clk); while (in_stall);
    board.note_beat(m, k);
    sent_count++;
  endtask

  // Bursty sender: drop valid for a random gap between bursts.
  task automatic offer(input logic m, input logic [kct_pkg::KEY_W-1:0] k);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        mode     <= 1'($urandom_range(0, 1));
        key_code <= kct_pkg::KEY_W'($urandom_range(0, 15));
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    send_beat(m, k);
  endtask

  task automatic press(input logic [kct_pkg::KEY_W-1:0] k);
    offer(MODE_KEY, k);
  endtask

  task automatic tick_beat();
    offer(MODE_TICK, kct_pkg::KEY_W'($urandom_range(0, 15)));
  endtask

  function automatic logic [kct_pkg::KEY_W-1:0] pick_letter();
    case ($urandom_range(0, 3))
      0:       return KEY_A;
      1:       return KEY_B;
      2:       return kct_pkg::KEY_C;
      default: return KEY_D;
    endcase
  endfunction

  task automatic type_digits(input int n, input bit tiny);
    repeat (n) begin
      if (tiny) press(kct_pkg::KEY_W'($urandom_range(0, 2)));
      else press(kct_pkg::KEY_W'($urandom_range(0, 9)));
    end
  endtask

  task automatic run_sequence();
    int  pick;
    int  n;
    bit  tiny;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      // noise: anything at all
      repeat ($urandom_range(1, 8))
        offer(1'($urandom_range(0, 1)), kct_pkg::KEY_W'($urandom_range(0, 15)));
      return;
    end
    tiny = ($urandom_range(0, 9) < 7);
    press(kct_pkg::KEY_HASH);
    if ($urandom_range(0, 4) == 0) press(pick_letter());
    type_digits(tiny ? $urandom_range(0, 1) : $urandom_range(0, 6), tiny);
    if ($urandom_range(0, 5) == 0) press(pick_letter());
    if ($urandom_range(0, 9) == 0) begin
      press(kct_pkg::KEY_HASH);
      return;
    end
    if ($urandom_range(0, 7) == 0) tick_beat();
    press(kct_pkg::KEY_STAR);
    type_digits(tiny ? $urandom_range(0, 2) : $urandom_range(0, 6), tiny);
    if ($urandom_range(0, 5) == 0) press(pick_letter() == kct_pkg::KEY_C ? KEY_A : KEY_D);
    pick = $urandom_range(0, 9);
    if (pick < 7) press(kct_pkg::KEY_STAR);
    else if (pick < 9) press(kct_pkg::KEY_HASH);
    else press(kct_pkg::KEY_C);
    n = tiny ? $urandom_range(0, 120) : $urandom_range(0, 40);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) press(kct_pkg::KEY_W'($urandom_range(0, 14)));
      else tick_beat();
    end
  endtask

  // Receiver: stall in shifting styles, with one long hold-off early on.
  initial begin : receiver
    int cyc;
    int style;
    int left;
    cyc   = 0;
    style = 0;
    left  = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 700) begin
        out_stall <= 1'b1;
        repeat (300) @(negedge clk);
        cyc += 300;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(5, 60);
      end
      left--;
      case (style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= 1'($urandom_range(0, 1));
        default: out_stall <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ticks at zero, run-phase keys that do nothing
    send_beat(MODE_TICK, 4'd0);
    send_beat(MODE_TICK, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, 4'd5);
    send_beat(MODE_KEY, kct_pkg::KEY_STAR);
    // minute entry: letters ignored, full digits, extra digit dropped
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, kct_pkg::KEY_C);
    send_beat(MODE_KEY, KEY_A);
    repeat (4) send_beat(MODE_KEY, 4'd9);
    send_beat(MODE_KEY, 4'd8);
    send_beat(MODE_TICK, 4'd3);
    send_beat(MODE_KEY, kct_pkg::KEY_STAR);
    // second entry at its top, load the largest time with hash
    repeat (4) send_beat(MODE_KEY, 4'd9);
    send_beat(MODE_KEY, 4'd0);
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_TICK, 4'd0);
    // cancel from minute entry, then from second entry
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, kct_pkg::KEY_STAR);
    send_beat(MODE_KEY, kct_pkg::KEY_C);
    // one-second load, run it out and tick at zero
    send_beat(MODE_KEY, kct_pkg::KEY_HASH);
    send_beat(MODE_KEY, kct_pkg::KEY_STAR);
    send_beat(MODE_KEY, 4'd1);
    send_beat(MODE_KEY, kct_pkg::KEY_STAR);
    send_beat(MODE_TICK, 4'd15);
    send_beat(MODE_TICK, 4'd0);

    while (sent_count < BEAT_TARGET) run_sequence();

    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_readouts.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d key and tick beats, checked %0d readouts.",
             sent_count, board.checked_count);
    $display("Timer loads %0d, entry cancels %0d, countdowns run to zero %0d.",
             board.load_count, board.cancel_count, board.expiry_count);
    if (board.mismatch_count == 0 && board.pending_readouts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", board.mismatch_count,
               board.pending_readouts.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
